### hw/rtl/fpa_pkg.sv
// Shared types and constants of the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int QUO_W     = DATA_W + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_LT    = 4'd4,
        OP_LE    = 4'd5,
        OP_GT    = 4'd6,
        OP_GE    = 4'd7,
        OP_EQ    = 4'd8,
        OP_NE    = 4'd9,
        OP_MIN   = 4'd10,
        OP_MAX   = 4'd11,
        OP_INC   = 4'd12,
        OP_DEC   = 4'd13,
        OP_ABS   = 4'd14,
        OP_TOINT = 4'd15
    } fpa_op_t;

    typedef struct packed {
        logic              is_div;
        logic              neg_q;
        logic              dz;
        logic              cmp;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] dvs;
        logic [DATA_W-1:0] rem;
        logic [QUO_W-1:0]  num;
    } fpa_item_t;

endpackage

### hw/rtl/fpa_front.sv
// Front stage: decode, simple operations, multiply and divider set-up.
module fpa_front
    import fpa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [3:0]               kind,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    output logic                     valid_reg,
    output fpa_item_t                item_reg
);

    fpa_item_t                     item_next;
    logic signed [2*DATA_W-1:0]    prod;
    logic signed [2*DATA_W-1:0]    prod_sh;
    logic [DATA_W-1:0]             a_mag;
    logic [DATA_W-1:0]             b_mag;
    logic                          lt;
    logic                          gt;
    logic                          eq;

    assign prod    = (2*DATA_W)'(operand_a) * (2*DATA_W)'(operand_b);
    assign prod_sh = prod >>> FRAC_BITS;
    assign a_mag   = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : operand_a;
    assign b_mag   = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : operand_b;
    assign lt      = operand_a < operand_b;
    assign gt      = operand_a > operand_b;
    assign eq      = operand_a == operand_b;

    always_comb
    begin
        item_next        = '0;
        item_next.dvs    = b_mag;
        item_next.num    = QUO_W'(a_mag) << FRAC_BITS;
        item_next.neg_q  = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
        case (fpa_op_t'(kind))
            OP_ADD:   item_next.res = operand_a + operand_b;
            OP_SUB:   item_next.res = operand_a - operand_b;
            OP_MUL:   item_next.res = prod_sh[DATA_W-1:0];
            OP_DIV:
            begin
                item_next.dz     = (operand_b == '0);
                item_next.is_div = (operand_b != '0);
            end
            OP_LT:    item_next.cmp = lt;
            OP_LE:    item_next.cmp = lt | eq;
            OP_GT:    item_next.cmp = gt;
            OP_GE:    item_next.cmp = gt | eq;
            OP_EQ:    item_next.cmp = eq;
            OP_NE:    item_next.cmp = !eq;
            OP_MIN:   item_next.res = lt ? operand_a : operand_b;
            OP_MAX:   item_next.res = gt ? operand_a : operand_b;
            OP_INC:   item_next.res = operand_a + DATA_W'(1);
            OP_DEC:   item_next.res = operand_a - DATA_W'(1);
            OP_ABS:   item_next.res = a_mag;
            OP_TOINT: item_next.res = operand_a >>> FRAC_BITS;
            default:  item_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/fpa_div_step.sv
// One restoring division step as a pipeline stage.
module fpa_div_step
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  fpa_item_t in_item,
    output logic      valid_reg,
    output fpa_item_t item_reg
);

    fpa_item_t         item_next;
    logic [DATA_W:0]   trial;

    assign trial = {in_item.rem, in_item.num[QUO_W-1]} - {1'b0, in_item.dvs};

    always_comb
    begin
        item_next     = in_item;
        item_next.num = {in_item.num[QUO_W-2:0], !trial[DATA_W]};
        item_next.rem = trial[DATA_W] ? {in_item.rem[DATA_W-2:0], in_item.num[QUO_W-1]}
                                      : trial[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/fpa_back.sv
// Output stage: quotient sign fix-up and result register.
module fpa_back
    import fpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  fpa_item_t         in_item,
    output logic              valid_reg,
    output logic [DATA_W-1:0] res_reg,
    output logic              cmp_reg,
    output logic              dz_reg
);

    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] res_next;

    assign quo      = in_item.num[DATA_W-1:0];
    assign res_next = !in_item.is_div ? in_item.res : (in_item.neg_q ? -quo : quo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            cmp_reg <= in_item.cmp;
            dz_reg  <= in_item.dz;
        end
    end

endmodule

### hw/rtl/fixed_point_alu.sv
// Top level of the pipelined Q24.8 fixed-point ALU.
//
// Input stream: s_axis_tuser carries the operation code, s_axis_tdata the
// two raw operands. Output stream: m_axis_tdata carries the result, the
// comparison outcome and the divide-by-zero flag. One transfer in gives
// exactly one transfer out, in order.
// Throughput: one transfer per cycle, every operation, while m_axis_tready stays high.
// Pipeline: one front stage (operate, multiply), one restoring division step per
// quotient bit, one output stage. All operations take the same path length.
// The whole pipeline advances on one enable; when the receiver holds
// m_axis_tready low with a result waiting, every stage holds and
// s_axis_tready falls. Empty stages hold as well, so bubbles are not squeezed out.
// Reset clears every stage valid bit; no result is shown after reset until
// a new transfer has passed through.
module fixed_point_alu
    import fpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // operand_a[31:0], operand_b[63:32]
    input  logic [3:0]  s_axis_tuser,  // kind[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result_value[31:0], compare_true[32],
                                       // divide_by_zero[33], zero[39:34]
);

    logic              en;
    logic              valid_q [QUO_W+1];
    fpa_item_t         item_q  [QUO_W+1];
    logic [DATA_W-1:0] res;
    logic              cmp;
    logic              dz;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tdata  = {6'b0, dz, cmp, res};

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .kind      (s_axis_tuser),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .valid_reg (valid_q[0]),
        .item_reg  (item_q[0])
    );

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        fpa_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_q[i]),
            .in_item   (item_q[i]),
            .valid_reg (valid_q[i+1]),
            .item_reg  (item_q[i+1])
        );
    end

    fpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_q[QUO_W]),
        .in_item   (item_q[QUO_W]),
        .valid_reg (m_axis_tvalid),
        .res_reg   (res),
        .cmp_reg   (cmp),
        .dz_reg    (dz)
    );

endmodule

### hw/rtl/fpa_checker.sv
// Port-level assertions for the fixed-point ALU, bound to the top level.
module fpa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [3:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer changed while stalled");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("divide by zero with non-zero result");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[33])
        else $error("comparison with non-zero result or flag");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

### tb/tb_fixed_point_alu.sv
// Testbench for the fixed-point ALU: scoreboard prediction and stream checks.
`timescale 1ns / 1ps

module tb_fixed_point_alu;
    import fpa_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        dz;
    } alu_result_t;

    class alu_scoreboard;
        alu_result_t pending[$];
        int          errors;

        function alu_result_t compute(fpa_op_t op, logic signed [31:0] a,
                                      logic signed [31:0] b);
            alu_result_t       r;
            logic signed [63:0] prod;
            logic signed [63:0] dvd;
            logic signed [63:0] quo;
            r = '0;
            case (op)
                OP_ADD:   r.value = a + b;
                OP_SUB:   r.value = a - b;
                OP_MUL:
                begin
                    prod = 64'(a) * 64'(b);
                    r.value = 32'(prod >>> FRAC_BITS);
                end
                OP_DIV:
                begin
                    if (b == 0)
                        r.dz = 1'b1;
                    else
                    begin
                        dvd = 64'(a) <<< FRAC_BITS;
                        quo = dvd / 64'(b);
                        r.value = 32'(quo);
                    end
                end
                OP_LT:    r.cmp = a < b;
                OP_LE:    r.cmp = a <= b;
                OP_GT:    r.cmp = a > b;
                OP_GE:    r.cmp = a >= b;
                OP_EQ:    r.cmp = a == b;
                OP_NE:    r.cmp = a != b;
                OP_MIN:   r.value = (a < b) ? a : b;
                OP_MAX:   r.value = (a > b) ? a : b;
                OP_INC:   r.value = a + 32'sd1;
                OP_DEC:   r.value = a - 32'sd1;
                OP_ABS:   r.value = (a < 0) ? -a : a;
                default:  r.value = a >>> FRAC_BITS;
            endcase
            return r;
        endfunction

        function void note_input(fpa_op_t op, logic [31:0] a, logic [31:0] b);
            pending.push_back(compute(op, a, b));
        endfunction

        function void check_result(logic [39:0] data);
            alu_result_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (data[31:0] !== exp_r.value)
            begin
                $display("%0t: value expected %h actual %h", $time, exp_r.value, data[31:0]);
                errors++;
            end
            if (data[32] !== exp_r.cmp)
            begin
                $display("%0t: compare expected %b actual %b", $time, exp_r.cmp, data[32]);
                errors++;
            end
            if (data[33] !== exp_r.dz)
            begin
                $display("%0t: div zero expected %b actual %b", $time, exp_r.dz, data[33]);
                errors++;
            end
            if (data[39:34] !== 6'd0)
            begin
                $display("%0t: pad expected 0 actual %h", $time, data[39:34]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    alu_scoreboard sb = new();
    int            send_idle_pct;
    int            recv_stall_pct;
    longint        cycles;

    fixed_point_alu DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_op(fpa_op_t op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(op, a, b);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3) - 1;
            1: return 32'($urandom_range(2000)) - 32'd1000;
            2: return 32'($urandom_range(1)) << FRAC_BITS;
            3: return 32'($urandom_range(65535)) << $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    logic [31:0] edges[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                              32'h0000_0100, 32'hffff_ff00};

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 16; k++)
            send_op(fpa_op_t'(k), edges[k % 6], edges[(k + 3) % 6]);
        send_op(OP_DIV, 32'h0000_0500, 32'h0);
        send_op(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
        send_op(OP_DIV, 32'hffff_fd00, 32'h0000_0300);
        send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_ABS, 32'h8000_0000, 32'h0);
        send_op(OP_TOINT, 32'hffff_ff80, 32'h0);
        send_op(OP_MIN, 32'h0000_1234, 32'h0000_1234);
        send_op(OP_MAX, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_INC, 32'h7fff_ffff, 32'h0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 13 : 0;
            recv_stall_pct = (phase == 2) ? 64 : (phase == 3) ? 13 : 0;
            for (int n = 0; n < 400; n++)
            begin
                logic [31:0] a;
                logic [31:0] b;
                a = rand_operand();
                b = ($urandom_range(9) == 0) ? a : rand_operand();
                if ($urandom_range(15) == 0)
                    b = 32'h0;
                send_op(fpa_op_t'($urandom_range(15)), a, b);
            end
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
